@@ rtl/mcr_pkg.sv @@
// shared types, constants and helpers for the mapping coverage / rho counter
// no dependencies
package mcr_pkg;

  localparam int HEAD_W         = 24;
  localparam int MAX_INDEX_BITS = 20;
  localparam int MIN_INDEX_BITS = 8;
  localparam int NUM_BINS       = 5;
  localparam int LIMIT_N        = 4;
  localparam int CNT_W          = 21;
  localparam int TALLY_W        = 32;
  localparam int BIN_W          = 3;
  localparam int LB_W           = 5;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // seen bitmap: rows of 64 bits, each tagged with the epoch of its last write
  localparam int BIT_W     = 6;
  localparam int ROW_BITS  = 1 << BIT_W;
  localparam int ROW_W     = MAX_INDEX_BITS - BIT_W;
  localparam int ROWS      = 1 << ROW_W;
  localparam int EPOCH_W   = 8;
  localparam int WORD_W    = EPOCH_W + ROW_BITS;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic MODE_RHO      = 1'b0;
  localparam logic MODE_COVERAGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEST_MODE  = 3'd0,
    REG_INDEX_BITS = 3'd1,
    REG_LIMIT_0    = 3'd2,
    REG_LIMIT_1    = 3'd3,
    REG_LIMIT_2    = 3'd4,
    REG_LIMIT_3    = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } seen_state_e;

  typedef struct packed {
    logic                           test_mode;
    logic [LB_W-1:0]                eff_bits;
    logic [LIMIT_N-1:0][CNT_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [BIT_W-1:0] bit_sel;
  } q_entry_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] stat;
  } run_t;

  function automatic logic [CNT_W-1:0] bin_limit_of(
    input logic [LIMIT_N-1:0][CNT_W-1:0] limit,
    input int                            j
  );
    logic [CNT_W-1:0] lim;
    lim = CNT_MAX;
    for (int k = 0; k < LIMIT_N; k++) begin
      if (k == j) begin
        lim = limit[k];
      end
    end
    return lim;
  endfunction

endpackage

@@ rtl/mapping_coverage_rho_counter_unit.sv @@
// top level of the mapping coverage / rho counter: configuration registers
// and the front, queue, bitmap and tally stages
// depends on mcr_pkg, mcr_front, mcr_queue, mcr_seen, mcr_tally
//
// Usage: each input beat on in_valid_i/in_ready_o carries one 24-bit keystream
// head. The top index_bits bits select a bit of the seen bitmap. Every input
// beat produces exactly one output beat on out_valid_o/out_ready_i; run_done_o
// marks beats that close a run (coverage: 2^L samples, rho: first repeat), and
// then carry the statistic, its bin and that bin's updated saturating tally.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i in one cycle
// and should only change while no beats are in flight.
// One beat per cycle is sustained while out_ready_i is high and no clearing pass
// runs; the bitmap sits in a single-port-write RAM of 16384 rows of
// 64 bits, read-modify-written each cycle with forwarding of the last write.
// Runs are cleared by an 8-bit epoch tag per row. After reset, and after every
// 255 finished runs when the epoch wraps, a clearing pass rewrites all 16384
// rows of the RAM while the input side fills the queue and then stalls.
// A stalled receiver backs up the pipeline and queue, then drops in_ready_o.
module mapping_coverage_rho_counter_unit
  import mcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HEAD_W-1:0]    keystream_head_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 run_done_o,
  output logic [CNT_W-1:0]     run_statistic_o,
  output logic [BIN_W-1:0]     bin_index_o,
  output logic [TALLY_W-1:0]   bin_tally_o
);

  logic                           mode_q;
  logic [LB_W-1:0]                lbits_q;
  logic [LIMIT_N-1:0][CNT_W-1:0]  limit_q;
  cfg_t                           cfg;
  logic                           push, q_ready, q_valid, q_pop, s_valid, s_ready;
  q_entry_t                       push_data, q_data;
  run_t                           s_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_COVERAGE;
      lbits_q    <= LB_W'(12);
      limit_q[0] <= CNT_W'(2572);
      limit_q[1] <= CNT_W'(2584);
      limit_q[2] <= CNT_W'(2594);
      limit_q[3] <= CNT_W'(2606);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEST_MODE:  mode_q     <= cfg_wdata_i[0];
        REG_INDEX_BITS: lbits_q    <= cfg_wdata_i[LB_W-1:0];
        REG_LIMIT_0:    limit_q[0] <= cfg_wdata_i;
        REG_LIMIT_1:    limit_q[1] <= cfg_wdata_i;
        REG_LIMIT_2:    limit_q[2] <= cfg_wdata_i;
        REG_LIMIT_3:    limit_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp the index width into the supported range
  always_comb begin
    cfg.test_mode = mode_q;
    cfg.limit     = limit_q;
    if (lbits_q < LB_W'(MIN_INDEX_BITS)) begin
      cfg.eff_bits = LB_W'(MIN_INDEX_BITS);
    end else if (lbits_q > LB_W'(MAX_INDEX_BITS)) begin
      cfg.eff_bits = LB_W'(MAX_INDEX_BITS);
    end else begin
      cfg.eff_bits = lbits_q;
    end
  end

  mcr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .eff_bits_i       (cfg.eff_bits),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .keystream_head_i (keystream_head_i),
    .push_o           (push),
    .q_ready_i        (q_ready),
    .push_data_o      (push_data)
  );

  mcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (q_ready),
    .push_data_i (push_data),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  mcr_seen u_seen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_data_i  (q_data),
    .s_valid_o (s_valid),
    .s_ready_i (s_ready),
    .s_data_o  (s_data)
  );

  mcr_tally u_tally (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .s_valid_i       (s_valid),
    .s_ready_o       (s_ready),
    .s_data_i        (s_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .run_done_o      (run_done_o),
    .run_statistic_o (run_statistic_o),
    .bin_index_o     (bin_index_o),
    .bin_tally_o     (bin_tally_o)
  );

endmodule

@@ rtl/mcr_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module mcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mcr_front.sv @@
// front stage: accepts keystream heads and turns them into bitmap row and bit
// depends on mcr_pkg
module mcr_front
  import mcr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LB_W-1:0]   eff_bits_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [HEAD_W-1:0] keystream_head_i,
  output logic              push_o,
  input  logic              q_ready_i,
  output q_entry_t          push_data_o
);

  logic                      fv_q, fv_d;
  q_entry_t                  ent_q, ent_d;
  logic [LB_W-1:0]           shamt;
  logic [HEAD_W-1:0]         shifted;
  logic [MAX_INDEX_BITS-1:0] idx;
  logic                      take;

  assign in_ready_o = !fv_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    shamt   = LB_W'(HEAD_W) - eff_bits_i;
    shifted = keystream_head_i >> shamt;
    idx     = shifted[MAX_INDEX_BITS-1:0];
    ent_d.row     = idx[MAX_INDEX_BITS-1:BIT_W];
    ent_d.bit_sel = idx[BIT_W-1:0];
  end

  always_comb begin
    fv_d = fv_q;
    if (take) begin
      fv_d = 1'b1;
    end else if (q_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ent_q <= ent_d;
    end
  end

  assign push_o      = fv_q;
  assign push_data_o = ent_q;

endmodule

@@ rtl/mcr_queue.sv @@
// short fifo between the front stage and the bitmap stage
// depends on mcr_pkg
module mcr_queue
  import mcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     ready_o,
  input  q_entry_t push_data_i,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t pop_data_o
);

  q_entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign ready_o    = cnt_q != QCNT_W'(QDEPTH);
  assign valid_o    = cnt_q != '0;
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/mcr_seen.sv @@
// bitmap read-modify-write with forwarding, run counters and epoch clearing
// depends on mcr_pkg and mcr_ram
module mcr_seen
  import mcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     q_valid_i,
  output logic     q_pop_o,
  input  q_entry_t q_data_i,
  output logic     s_valid_o,
  input  logic     s_ready_i,
  output run_t     s_data_o
);

  seen_state_e          state_q, state_d;
  logic [ROW_W-1:0]     clr_q, clr_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [CNT_W-1:0]     sample_q, sample_d, distinct_q, distinct_d;
  logic                 b2v_q, b2v_d;
  q_entry_t             b2_q;
  logic                 byp_v_q;
  logic [ROW_W-1:0]     byp_row_q;
  logic [WORD_W-1:0]    byp_word_q;
  logic                 sv_q, sv_d;
  run_t                 sr_q, sr_d;

  logic                 adv, b2_fire, wrap, pop;
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata, word;
  logic [ROW_BITS-1:0]  bits, bits_new;
  logic                 was_seen, done;
  logic [CNT_W-1:0]     sample_nx, distinct_nx, cov_len;

  mcr_ram #(
    .Width (WORD_W),
    .Depth (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    word = (byp_v_q && byp_row_q == b2_q.row) ? byp_word_q : ram_rdata;
    bits = (word[WORD_W-1:ROW_BITS] == epoch_q) ? word[ROW_BITS-1:0] : '0;
    was_seen = bits[b2_q.bit_sel];
    bits_new = bits | (ROW_BITS'(1) << b2_q.bit_sel);
    sample_nx   = (sample_q == CNT_MAX) ? sample_q : sample_q + CNT_W'(1);
    distinct_nx = (was_seen || distinct_q == CNT_MAX) ? distinct_q
                                                      : distinct_q + CNT_W'(1);
    cov_len = CNT_W'(1) << cfg_i.eff_bits;
    if (cfg_i.test_mode == MODE_RHO) begin
      done = was_seen;
    end else begin
      done = sample_nx >= cov_len;
    end
  end

  assign adv     = !sv_q || s_ready_i;
  assign b2_fire = b2v_q && adv;
  assign wrap    = b2_fire && done && epoch_q == EPOCH_MAX;
  assign pop     = q_valid_i && state_q == ST_RUN && (!b2v_q || b2_fire) && !wrap;
  assign q_pop_o = pop;

  // ram port control
  always_comb begin
    ram_raddr = pop ? q_data_i.row : b2_q.row;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = {EPOCH_CLEAR, {ROW_BITS{1'b0}}};
    end else begin
      ram_we    = b2_fire;
      ram_waddr = b2_q.row;
      ram_wdata = {epoch_q, bits_new};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (wrap) begin
          state_d = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath updates
  always_comb begin
    clr_d      = (state_q == ST_CLEAR) ? clr_q + ROW_W'(1) : '0;
    epoch_d    = epoch_q;
    sample_d   = sample_q;
    distinct_d = distinct_q;
    b2v_d      = b2v_q;
    sv_d       = sv_q;
    sr_d       = sr_q;
    if (b2_fire) begin
      if (done) begin
        sample_d   = '0;
        distinct_d = '0;
        epoch_d    = (epoch_q == EPOCH_MAX) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
      end else begin
        sample_d   = sample_nx;
        distinct_d = distinct_nx;
      end
    end
    if (pop) begin
      b2v_d = 1'b1;
    end else if (b2_fire) begin
      b2v_d = 1'b0;
    end
    if (adv) begin
      sv_d      = b2v_q;
      sr_d.done = done;
      sr_d.stat = (cfg_i.test_mode == MODE_RHO) ? sample_nx : distinct_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      epoch_q    <= EPOCH_FIRST;
      sample_q   <= '0;
      distinct_q <= '0;
      b2v_q      <= 1'b0;
      sv_q       <= 1'b0;
      byp_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      epoch_q    <= epoch_d;
      sample_q   <= sample_d;
      distinct_q <= distinct_d;
      b2v_q      <= b2v_d;
      sv_q       <= sv_d;
      byp_v_q    <= b2_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b2_q <= q_data_i;
    end
    if (b2_fire) begin
      byp_row_q  <= b2_q.row;
      byp_word_q <= ram_wdata;
    end
    sr_q <= sr_d;
  end

  assign s_valid_o = sv_q;
  assign s_data_o  = sr_q;

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !b2v_q && !pop)
    else $error("bitmap stage holds an item during the clearing pass");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != EPOCH_CLEAR)
    else $error("live epoch equals the cleared tag");

  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap |=> state_q == ST_CLEAR && epoch_q == EPOCH_FIRST && sample_q == '0)
    else $error("epoch wrap did not start a clearing pass");

  a_counts_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= sample_q)
    else $error("distinct count exceeds sample count");

endmodule

@@ rtl/mcr_tally.sv @@
// binning of finished runs, saturating bin tallies and the output register
// depends on mcr_pkg
module mcr_tally
  import mcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  run_t                s_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                run_done_o,
  output logic [CNT_W-1:0]    run_statistic_o,
  output logic [BIN_W-1:0]    bin_index_o,
  output logic [TALLY_W-1:0]  bin_tally_o
);

  logic                 bv_q, bv_d;
  logic                 bdone_q;
  logic [CNT_W-1:0]     bstat_q;
  logic [BIN_W-1:0]     bbin_q, bin_d;
  logic                 ov_q, ov_d;
  logic                 odone_q;
  logic [CNT_W-1:0]     ostat_q;
  logic [BIN_W-1:0]     obin_q;
  logic [TALLY_W-1:0]   otally_q;
  logic [TALLY_W-1:0]   tally_q [NUM_BINS];
  logic [TALLY_W-1:0]   tally_nx;
  logic                 out_adv, bin_adv, load_out;

  assign out_adv   = !ov_q || out_ready_i;
  assign bin_adv   = !bv_q || out_adv;
  assign s_ready_o = bin_adv;
  assign load_out  = out_adv && bv_q;

  always_comb begin
    bin_d = BIN_W'(NUM_BINS - 1);
    for (int j = NUM_BINS - 2; j >= 0; j--) begin
      if (s_data_i.stat <= bin_limit_of(cfg_i.limit, j)) begin
        bin_d = BIN_W'(j);
      end
    end
  end

  always_comb begin
    tally_nx = (tally_q[bbin_q] == TALLY_MAX) ? tally_q[bbin_q]
                                              : tally_q[bbin_q] + TALLY_W'(1);
    bv_d = bin_adv ? s_valid_i : bv_q;
    ov_d = out_adv ? bv_q : ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0;
      ov_q <= 1'b0;
      for (int j = 0; j < NUM_BINS; j++) begin
        tally_q[j] <= '0;
      end
    end else begin
      bv_q <= bv_d;
      ov_q <= ov_d;
      if (load_out && bdone_q) begin
        tally_q[bbin_q] <= tally_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bin_adv) begin
      bdone_q <= s_data_i.done;
      bstat_q <= s_data_i.stat;
      bbin_q  <= bin_d;
    end
    if (load_out) begin
      odone_q  <= bdone_q;
      ostat_q  <= bdone_q ? bstat_q : '0;
      obin_q   <= bdone_q ? bbin_q : '0;
      otally_q <= bdone_q ? tally_nx : '0;
    end
  end

  assign out_valid_o     = ov_q;
  assign run_done_o      = odone_q;
  assign run_statistic_o = ostat_q;
  assign bin_index_o     = obin_q;
  assign bin_tally_o     = otally_q;

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && odone_q |-> obin_q < BIN_W'(NUM_BINS))
    else $error("bin index out of range");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !odone_q |-> ostat_q == '0 && otally_q == '0)
    else $error("result without a finished run carries data");

  a_tally_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && odone_q |-> otally_q != '0)
    else $error("finished run reports a zero tally");

endmodule

@@ test/mcr_run_checker.sv @@
// result checker for the mapping coverage / rho counter: tracks register writes,
// predicts one result beat per accepted keystream beat and compares in order
// depends on mcr_pkg
module mcr_run_checker
  import mcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [HEAD_W-1:0]    keystream_head_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 run_done_i,
  input  logic [CNT_W-1:0]     run_statistic_i,
  input  logic [BIN_W-1:0]     bin_index_i,
  input  logic [TALLY_W-1:0]   bin_tally_i,
  output int                   mismatches_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LB_W-1:0]  RESET_BITS = LB_W'(12);
  localparam logic [CNT_W-1:0] RESET_LIMIT [LIMIT_N] = '{
    CNT_W'(2572), CNT_W'(2584), CNT_W'(2594), CNT_W'(2606)
  };
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic               run_done;
    logic [CNT_W-1:0]   stat;
    logic [BIN_W-1:0]   bin_idx;
    logic [TALLY_W-1:0] tally;
  } outcome_t;

  logic               cur_mode;
  logic [LB_W-1:0]    cur_bits;
  logic [CNT_W-1:0]   cur_limit [LIMIT_N];
  logic [CNT_W-1:0]   sample_cnt;
  logic [CNT_W-1:0]   distinct_cnt;
  logic [TALLY_W-1:0] tally [NUM_BINS];
  bit                 seen_idx [int unsigned];
  outcome_t           outcome_q [$];
  int                 mismatch_cnt;
  int                 beat_no;

  function automatic outcome_t predict_run_outcome(input logic [HEAD_W-1:0] head);
    int unsigned      l;
    int unsigned      idx;
    int unsigned      b;
    logic             was_seen;
    logic             ended;
    logic [CNT_W-1:0] stat;
    logic [CNT_W-1:0] lim;
    outcome_t         res;
    res   = '0;
    ended = 1'b0;
    stat  = '0;
    l = cur_bits;
    if (l < MIN_INDEX_BITS) l = MIN_INDEX_BITS;
    if (l > MAX_INDEX_BITS) l = MAX_INDEX_BITS;
    idx = head >> (HEAD_W - l);
    was_seen = seen_idx.exists(idx);
    if (!was_seen) begin
      seen_idx[idx] = 1'b1;
      if (distinct_cnt != CNT_MAX) distinct_cnt++;
    end
    if (sample_cnt != CNT_MAX) sample_cnt++;
    if (cur_mode == MODE_RHO) begin
      ended = was_seen;
      stat  = sample_cnt;
    end else if (32'(sample_cnt) >= (32'd1 << l)) begin
      ended = 1'b1;
      stat  = distinct_cnt;
    end
    if (ended) begin
      b = NUM_BINS - 1;
      for (int j = NUM_BINS - 2; j >= 0; j--) begin
        lim = (j < LIMIT_N) ? cur_limit[j] : CNT_MAX;
        if (stat <= lim) b = j;
      end
      if (tally[b] != TALLY_MAX) tally[b]++;
      res.run_done = 1'b1;
      res.stat     = stat;
      res.bin_idx  = BIN_W'(b);
      res.tally    = tally[b];
      seen_idx.delete();
      sample_cnt   = '0;
      distinct_cnt = '0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      cur_mode     = MODE_COVERAGE;
      cur_bits     = RESET_BITS;
      cur_limit    = RESET_LIMIT;
      sample_cnt   = '0;
      distinct_cnt = '0;
      foreach (tally[k]) tally[k] = '0;
      seen_idx.delete();
      outcome_q.delete();
      mismatch_cnt = 0;
      beat_no      = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEST_MODE:  cur_mode = cfg_wdata_i[0];
          REG_INDEX_BITS: cur_bits = cfg_wdata_i[LB_W-1:0];
          REG_LIMIT_0:    cur_limit[0] = cfg_wdata_i;
          REG_LIMIT_1:    cur_limit[1] = cfg_wdata_i;
          REG_LIMIT_2:    cur_limit[2] = cfg_wdata_i;
          REG_LIMIT_3:    cur_limit[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{run_done_i, run_statistic_i, bin_index_i, bin_tally_i};
        beat_no++;
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("result beat %0d with nothing expected: done %0d stat %0d bin %0d tally %0d",
                     beat_no, got.run_done, got.stat, got.bin_idx, got.tally);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("result beat %0d: expected done %0d stat %0d bin %0d tally %0d, got done %0d stat %0d bin %0d tally %0d",
                       beat_no, want.run_done, want.stat, want.bin_idx, want.tally,
                       got.run_done, got.stat, got.bin_idx, got.tally);
          end
        end
      end
      if (in_valid_i && in_ready_i) outcome_q.push_back(predict_run_outcome(keystream_head_i));
      pending_o    <= outcome_q.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

@@ test/tb_mapping_coverage_rho_counter_unit.sv @@
// testbench top for mapping_coverage_rho_counter_unit: clock, reset, register
// writes, keystream beats and output back-pressure; verdict from mcr_run_checker
// depends on mcr_pkg, mcr_run_checker and the unit under test
module tb_mapping_coverage_rho_counter_unit
  import mcr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_SLACK = 8;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_LEN    = 400;
  localparam int POOL_N      = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CNT_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic [HEAD_W-1:0]    head      = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 run_done;
  logic [CNT_W-1:0]     run_stat;
  logic [BIN_W-1:0]     bin_index;
  logic [TALLY_W-1:0]   bin_tally;

  int          mismatch_total;
  int          results_pending;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          head_bits = 12;
  int unsigned head_pool [POOL_N];
  int unsigned sweep_idx;
  int          items_sent  = 0;
  int          phases_run  = 0;
  int          out_beats   = 0;
  int          runs_closed = 0;
  int          hold_left   = 0;
  logic        held_once   = 1'b0;

  mapping_coverage_rho_counter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .keystream_head_i(head),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .run_done_o      (run_done),
    .run_statistic_o (run_stat),
    .bin_index_o     (bin_index),
    .bin_tally_o     (bin_tally)
  );

  mcr_run_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .keystream_head_i(head),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .run_done_i      (run_done),
    .run_statistic_i (run_stat),
    .bin_index_i     (bin_index),
    .bin_tally_i     (bin_tally),
    .mismatches_o    (mismatch_total),
    .pending_o       (results_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_beats <= out_beats + 1;
        if (run_done) runs_closed <= runs_closed + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && out_beats >= HOLD_AT) begin
        held_once <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic send_head(input logic [HEAD_W-1:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    head     <= h;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [HEAD_W-1:0] head_for(input int unsigned idx);
    logic [HEAD_W-1:0] low_mask;
    low_mask = (HEAD_W'(1) << (HEAD_W - head_bits)) - HEAD_W'(1);
    return (HEAD_W'(idx) << (HEAD_W - head_bits)) | (HEAD_W'($urandom()) & low_mask);
  endfunction

  task automatic configure(input logic mode, input logic [LB_W-1:0] lbits,
                           input logic [CNT_W-1:0] lim0, input logic [CNT_W-1:0] lim1,
                           input logic [CNT_W-1:0] lim2, input logic [CNT_W-1:0] lim3);
    logic [CNT_W-1:0] noise;
    wait_drained();
    noise = CNT_W'($urandom());
    write_reg(REG_TEST_MODE, {noise[CNT_W-1:1], mode});
    noise = CNT_W'($urandom());
    write_reg(REG_INDEX_BITS, {noise[CNT_W-1:LB_W], lbits});
    write_reg(REG_LIMIT_0, lim0);
    write_reg(REG_LIMIT_1, lim1);
    write_reg(REG_LIMIT_2, lim2);
    write_reg(REG_LIMIT_3, lim3);
    cfg_we <= 1'b0;
    if (lbits < MIN_INDEX_BITS) head_bits = MIN_INDEX_BITS;
    else if (lbits > MAX_INDEX_BITS) head_bits = MAX_INDEX_BITS;
    else head_bits = lbits;
    foreach (head_pool[k]) head_pool[k] = $urandom_range((1 << head_bits) - 1, 0);
    sweep_idx = 0;
  endtask

  task automatic run_phase(input logic mode, input logic [LB_W-1:0] lbits,
                           input logic [CNT_W-1:0] lim0, input logic [CNT_W-1:0] lim1,
                           input logic [CNT_W-1:0] lim2, input logic [CNT_W-1:0] lim3,
                           input int count, input int pool_pct, input int sweep_pct);
    int pick;
    configure(mode, lbits, lim0, lim1, lim2, lim3);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < pool_pct) begin
        send_head(head_for(head_pool[$urandom_range(POOL_N - 1)]));
      end else if (pick < pool_pct + sweep_pct) begin
        send_head(head_for(sweep_idx));
        sweep_idx = (sweep_idx + 1) % (1 << head_bits);
      end else begin
        send_head(HEAD_W'($urandom()));
      end
    end
    phases_run++;
  endtask

  function automatic logic [CNT_W-1:0] rnd_limit(input int unsigned top);
    return CNT_W'($urandom_range(top, 0));
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: repeats at both index width extremes, bin edges, ignored indexes
    configure(MODE_RHO, LB_W'(8), CNT_W'(1), CNT_W'(2), CNT_W'(3), CNT_W'(4));
    send_head(24'h000000);
    send_head(24'hFFFFFF);
    send_head(24'h000000);
    send_head(24'h123456);
    send_head(24'h123456);
    send_head(24'h00FFFF);
    send_head(24'h00AAAA);
    configure(MODE_RHO, LB_W'(31), CNT_W'(0), CNT_W'(1), CNT_MAX, CNT_W'(0));
    send_head(24'hABCDEF);
    send_head(24'hABCDE0);
    send_head(24'hFFFFF0);
    send_head(24'hFFFFFF);
    configure(MODE_RHO, LB_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0));
    send_head(24'h01FFFF);
    send_head(24'h010000);
    wait_drained();
    write_reg(REG_SPARE_A, CNT_W'($urandom()));
    write_reg(REG_SPARE_B, CNT_W'($urandom()));
    cfg_we <= 1'b0;

    send_idle = 8;
    recv_idle <= 84;
    run_phase(MODE_RHO, LB_W'(8), CNT_W'(4), CNT_W'(8), CNT_W'(16), CNT_W'(32), 120, 20, 0);
    run_phase(MODE_COVERAGE, LB_W'(8), CNT_W'(150), CNT_W'(160), CNT_W'(165), CNT_W'(170),
              260, 0, 50);
    run_phase(MODE_RHO, LB_W'(31), CNT_W'(1), CNT_W'(2), CNT_W'(3), CNT_MAX, 60, 80, 0);

    send_idle = 84;
    recv_idle <= 8;
    run_phase(MODE_RHO, LB_W'(0), rnd_limit(40), rnd_limit(40), rnd_limit(40), rnd_limit(40),
              150, 10, 0);
    run_phase(MODE_COVERAGE, LB_W'(8), CNT_W'(170), CNT_W'(100), CNT_W'(160), CNT_W'(1048577),
              260, 30, 20);
    run_phase(MODE_RHO, LB_W'(21), CNT_W'(0), CNT_W'(0), CNT_W'(0), CNT_W'(0), 40, 90, 0);

    send_idle = 0;
    recv_idle <= 0;
    run_phase(MODE_RHO, LB_W'(9), rnd_limit(60), rnd_limit(60), rnd_limit(60), rnd_limit(60),
              100, 20, 0);
    run_phase(MODE_COVERAGE, LB_W'(7), CNT_W'(255), CNT_W'(256), CNT_W'(257), CNT_W'(1048577),
              256, 0, 100);
    run_phase(MODE_RHO, LB_W'(12), CNT_W'($urandom()), CNT_W'($urandom()), CNT_W'($urandom()),
              CNT_W'($urandom()), 60, 60, 0);

    wait_drained();
    $display("%0d keystream beats over %0d phases, %0d runs closed in rho and coverage mode",
             items_sent, phases_run, runs_closed);
    $display("index widths below 8 through above 20, ordered and unordered bin limits, long stall");
    if (mismatch_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
